// ===== hw/rtl/hill_block_decrypt_macros.svh =====
// assertion helpers for the hill block decrypt checker
`ifndef HILL_BLOCK_DECRYPT_MACROS_SVH
`define HILL_BLOCK_DECRYPT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HBD_CHECK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HBD_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hbd_pkg.sv =====
`timescale 1ns / 1ps

package hbd_pkg;

    localparam int CODE_W      = 5;
    localparam int KEY_INDEX_W = 4;
    localparam int KEY_SIZE_W  = 3;
    localparam int PROD_W      = 2 * CODE_W;
    localparam int MODULUS     = 26;

    localparam logic CMD_KEY    = 1'b0;
    localparam logic CMD_LETTER = 1'b1;

    typedef struct packed {
        logic                   command;
        logic [KEY_INDEX_W-1:0] key_index;
        logic [CODE_W-1:0]      key_value;
        logic [CODE_W-1:0]      letter_code;
        logic                   last_letter;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] plain_code;
        logic              last_of_block;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    // residue mod 26 of a value below 1024 by six compare-subtract steps
    function automatic logic [CODE_W-1:0] mod26(input logic [PROD_W-1:0] a);
        logic [PROD_W-1:0] x;
        x = a;
        for (int s = 5; s >= 0; s--) begin
            if (x >= PROD_W'(MODULUS << s)) begin
                x = x - PROD_W'(MODULUS << s);
            end
        end
        return x[CODE_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/hill_block_decrypt.sv =====
`timescale 1ns / 1ps

// Hill block decryption mod 26. A key item (command 0) writes one inverse-key
// entry. Letter items (command 1) are taken one per cycle while a k-by-k
// block fills row by row; the letter that fills the block, or one marked
// last, starts a flush. During a flush the input stalls until the final
// result leaves the cell chain; the k*k products of Kinv * C enter a chain
// of MAX_KEY cells one per cycle while the output does not stall, each cell
// holding one key column and one block row and adding its term mod 26 over
// two register stages. Results leave in row-major order, the final one of
// each block marked with last_of_block. The next item is taken while the
// final result still waits in the output register. Key size is written on
// the configuration port while idle; 0 acts as 1 and values above MAX_KEY
// as MAX_KEY, and a write drops any partly filled block.
module hill_block_decrypt #(
    parameter int MAX_KEY = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  hbd_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hbd_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hbd_pkg::KEY_SIZE_W-1:0]    i_cfg_data
);
    import hbd_pkg::*;

    localparam int IW = $clog2(MAX_KEY);
    localparam int KW = $clog2(MAX_KEY + 1);

    logic [KW-1:0] r_side;
    logic [IW-1:0] r_fill_row;
    logic [IW-1:0] r_fill_col;
    logic          r_busy;
    logic          r_issue;
    logic [IW-1:0] r_iss_row;
    logic [IW-1:0] r_iss_col;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [KW-1:0] n_side;
    logic [KW-1:0] side_m1;
    logic          in_acc;
    logic          cfg_acc;
    logic          letter_acc;
    logic          key_acc;
    logic          fill_col_end;
    logic          fill_full;
    logic          flush;
    logic          iss_col_end;
    logic          iss_last;
    logic          advance;

    t_tag              w_tag [0:MAX_KEY];
    logic [IW-1:0]     w_row [0:MAX_KEY];
    logic [IW-1:0]     w_col [0:MAX_KEY];
    logic [CODE_W-1:0] w_sum [0:MAX_KEY];

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = !r_busy;
    assign in_acc      = i_in_valid && !r_busy;
    assign cfg_acc     = i_cfg_valid && !r_busy;
    assign letter_acc  = in_acc && (i_in_item.command == CMD_LETTER);
    assign key_acc     = in_acc && (i_in_item.command == CMD_KEY);
    assign advance     = !r_out_valid || !i_out_stall;

    assign side_m1      = r_side - KW'(1);
    assign fill_col_end = (KW'(r_fill_col) == side_m1);
    assign fill_full    = fill_col_end && (KW'(r_fill_row) == side_m1);
    assign flush        = letter_acc && (fill_full || i_in_item.last_letter);
    assign iss_col_end  = (KW'(r_iss_col) == side_m1);
    assign iss_last     = iss_col_end && (KW'(r_iss_row) == side_m1);

    always_comb begin
        if (i_cfg_data == '0) begin
            n_side = KW'(1);
        end else if (int'(i_cfg_data) > MAX_KEY) begin
            n_side = KW'(MAX_KEY);
        end else begin
            n_side = KW'(i_cfg_data);
        end
    end

    // block fill position and key size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= KW'(2);
            r_fill_row <= '0;
            r_fill_col <= '0;
        end else if (cfg_acc) begin
            r_side     <= n_side;
            r_fill_row <= '0;
            r_fill_col <= '0;
        end else if (letter_acc) begin
            if (flush) begin
                r_fill_row <= '0;
                r_fill_col <= '0;
            end else if (fill_col_end) begin
                r_fill_row <= r_fill_row + IW'(1);
                r_fill_col <= '0;
            end else begin
                r_fill_col <= r_fill_col + IW'(1);
            end
        end
    end

    // flush sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_iss_row <= '0;
            r_iss_col <= '0;
        end else begin
            if (flush) begin
                r_busy    <= 1'b1;
                r_issue   <= 1'b1;
                r_iss_row <= '0;
                r_iss_col <= '0;
            end else if (r_issue && advance) begin
                if (iss_last) begin
                    r_issue <= 1'b0;
                end else if (iss_col_end) begin
                    r_iss_row <= r_iss_row + IW'(1);
                    r_iss_col <= '0;
                end else begin
                    r_iss_col <= r_iss_col + IW'(1);
                end
            end
            if (advance && w_tag[MAX_KEY].valid && w_tag[MAX_KEY].last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign w_tag[0] = '{valid: r_issue, last: iss_last};
    assign w_row[0] = r_iss_row;
    assign w_col[0] = r_iss_col;
    assign w_sum[0] = '0;

    for (genvar g = 0; g < MAX_KEY; g++) begin : g_cell
        hbd_cell #(
            .MAX_KEY  (MAX_KEY),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_active    (int'(r_side) > g),
            .i_key_we    (key_acc),
            .i_key_index (i_in_item.key_index),
            .i_key_value (i_in_item.key_value),
            .i_blk_we    (letter_acc),
            .i_blk_row   (r_fill_row),
            .i_blk_col   (r_fill_col),
            .i_blk_data  (i_in_item.letter_code),
            .i_tag       (w_tag[g]),
            .i_row       (w_row[g]),
            .i_col       (w_col[g]),
            .i_sum       (w_sum[g]),
            .o_tag       (w_tag[g+1]),
            .o_row       (w_row[g+1]),
            .o_col       (w_col[g+1]),
            .o_sum       (w_sum[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= w_tag[MAX_KEY].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.plain_code    <= w_sum[MAX_KEY];
            r_out.last_of_block <= w_tag[MAX_KEY].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hw/rtl/hbd_cell.sv =====
`timescale 1ns / 1ps

module hbd_cell #(
    parameter int MAX_KEY  = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_active,
    input  logic                           i_key_we,
    input  logic [hbd_pkg::KEY_INDEX_W-1:0] i_key_index,
    input  logic [hbd_pkg::CODE_W-1:0]     i_key_value,
    input  logic                           i_blk_we,
    input  logic [$clog2(MAX_KEY)-1:0]     i_blk_row,
    input  logic [$clog2(MAX_KEY)-1:0]     i_blk_col,
    input  logic [hbd_pkg::CODE_W-1:0]     i_blk_data,
    input  hbd_pkg::t_tag                  i_tag,
    input  logic [$clog2(MAX_KEY)-1:0]     i_row,
    input  logic [$clog2(MAX_KEY)-1:0]     i_col,
    input  logic [hbd_pkg::CODE_W-1:0]     i_sum,
    output hbd_pkg::t_tag                  o_tag,
    output logic [$clog2(MAX_KEY)-1:0]     o_row,
    output logic [$clog2(MAX_KEY)-1:0]     o_col,
    output logic [hbd_pkg::CODE_W-1:0]     o_sum
);
    import hbd_pkg::*;

    localparam int IW = $clog2(MAX_KEY);

    // key column CELL_IDX and block row CELL_IDX
    logic [CODE_W-1:0] r_key [0:MAX_KEY-1];
    logic [CODE_W-1:0] r_blk [0:MAX_KEY-1];

    t_tag              r_a_tag;
    logic [IW-1:0]     r_a_row;
    logic [IW-1:0]     r_a_col;
    logic [CODE_W-1:0] r_a_sum;
    logic [PROD_W-1:0] r_a_prod;
    t_tag              r_b_tag;
    logic [IW-1:0]     r_b_row;
    logic [IW-1:0]     r_b_col;
    logic [CODE_W-1:0] r_b_sum;

    logic [PROD_W-1:0] n_prod;
    logic [CODE_W-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_KEY; r++) begin
                r_key[r] <= '0;
                r_blk[r] <= '0;
            end
        end else begin
            for (int r = 0; r < MAX_KEY; r++) begin
                if (i_key_we && (int'(i_key_index) == r * MAX_KEY + CELL_IDX)) begin
                    r_key[r] <= i_key_value;
                end
            end
            if (i_blk_we && (int'(i_blk_row) == CELL_IDX)) begin
                r_blk[i_blk_col] <= i_blk_data;
            end
        end
    end

    always_comb begin
        if (i_active) begin
            n_prod = {{CODE_W{1'b0}}, r_key[i_row]} * {{CODE_W{1'b0}}, r_blk[i_col]};
        end else begin
            n_prod = '0;
        end
        n_sum = mod26({{CODE_W{1'b0}}, r_a_sum} + r_a_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
        end else if (i_advance) begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_row  <= i_row;
            r_a_col  <= i_col;
            r_a_sum  <= i_sum;
            r_a_prod <= n_prod;
            r_b_row  <= r_a_row;
            r_b_col  <= r_a_col;
            r_b_sum  <= n_sum;
        end
    end

    assign o_tag = r_b_tag;
    assign o_row = r_b_row;
    assign o_col = r_b_col;
    assign o_sum = r_b_sum;

endmodule

// ===== hw/rtl/hbd_checker.sv =====
`timescale 1ns / 1ps
`include "hill_block_decrypt_macros.svh"

module hbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input hbd_pkg::t_in_item              i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input hbd_pkg::t_out_item             o_out_item,
    input logic                           o_cfg_ready
);
    import hbd_pkg::*;

    `HBD_CHECK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item), "stalled result item changed")

    `HBD_CHECK_NEXT(a_key_no_stall, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_in_item.command == CMD_KEY),
        !o_in_stall, "key item caused a stall")

    `HBD_CHECK_SAME(a_stall_from_letter, i_clk, i_rst_n, $rose(o_in_stall),
        $past(i_in_valid && !o_in_stall && (i_in_item.command == CMD_LETTER)),
        "input stall rose without a letter item")

    `HBD_CHECK_SAME(a_last_frees_input, i_clk, i_rst_n,
        o_out_valid && o_out_item.last_of_block && !$past(o_out_valid && i_out_stall),
        !o_in_stall && o_cfg_ready, "input still stalled after final result of block")

endmodule

bind hill_block_decrypt hbd_checker u_hbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .o_cfg_ready (o_cfg_ready)
);
